@@ rtl/hagc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hagc_pkg: shared types and constants for the hang AGC gain tracker
// Reset values, register indexes, sequencer states and the modes of the
// shared shift-subtract unit.
// ----------------------------------------------------------------------------
package hagc_pkg;

  localparam int POWER_W   = 40;
  localparam int AMP_W     = 20;
  localparam int GAIN_W    = 32;
  localparam int HEAD_W    = 16;
  localparam int RATIO_W   = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int REM_W     = 24;
  localparam int CNT_W     = 5;

  localparam int HANG_WIDTH_DEF = 16;

  localparam int SQRT_STEPS = 20;
  localparam int DIV_STEPS  = 32;

  localparam logic [GAIN_W-1:0]  GAIN_RESET        = 32'd207243031;
  localparam logic [HEAD_W-1:0]  HEADROOM_RESET    = 16'd20724;
  localparam logic [15:0]        HANG_BLOCKS_RESET = 16'd55;
  localparam logic [RATIO_W-1:0] RATIO_RESET       = 32'd1088677572;

  localparam logic [CFG_IDX_W-1:0] REG_HEADROOM    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HANG_BLOCKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO       = 2'd2;

  typedef enum logic {
    MODE_SQRT,
    MODE_DIV
  } iter_mode_t;

  typedef struct packed {
    logic       start;
    iter_mode_t mode;
  } iter_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_LEVEL,
    ST_DECIDE,
    ST_DIV,
    ST_RECOV,
    ST_OUT
  } state_t;

endpackage

@@ rtl/hagc_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hagc_mul: registered 32 x 32 multiplier
// Shared between the peak test and the recovery step; the product is
// registered and appears in the cycle after its operands.
// ----------------------------------------------------------------------------
module hagc_mul (
  input  logic                          clk,
  input  logic [hagc_pkg::GAIN_W-1:0]   a,
  input  logic [hagc_pkg::RATIO_W-1:0]  b,
  output logic [hagc_pkg::GAIN_W+hagc_pkg::RATIO_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

@@ rtl/hagc_iter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hagc_iter: shared shift-subtract unit
// Restoring square root, two radicand bits a step, or restoring division,
// one dividend bit a step. One result bit per cycle.
// ----------------------------------------------------------------------------
module hagc_iter (
  input  logic                          clk,
  input  logic                          rst,
  input  hagc_pkg::iter_ctl_t           ctl,
  input  logic [hagc_pkg::POWER_W-1:0]  operand,  // radicand, or dividend in top bits
  input  logic [hagc_pkg::AMP_W-1:0]    divisor,
  output hagc_pkg::iter_sts_t           sts,
  output logic [hagc_pkg::GAIN_W-1:0]   result
);

  localparam int P_W = hagc_pkg::POWER_W;
  localparam int R_W = hagc_pkg::REM_W;

  logic [P_W-1:0]              src;
  logic [R_W-1:0]              rem;
  logic [hagc_pkg::GAIN_W-1:0] acc;
  logic [hagc_pkg::AMP_W-1:0]  dvs;
  logic [hagc_pkg::CNT_W-1:0]  count;
  hagc_pkg::iter_mode_t        mode;
  logic                        busy;
  logic                        done;

  logic [R_W-1:0] rem_sh;
  logic [R_W-1:0] trial;
  logic [R_W:0]   diff;
  logic [P_W-1:0] src_next;

  always_comb begin
    unique case (mode)
      hagc_pkg::MODE_SQRT: begin
        rem_sh   = {rem[R_W-3:0], src[P_W-1 -: 2]};
        trial    = {2'b00, acc[hagc_pkg::AMP_W-1:0], 2'b01};
        src_next = {src[P_W-3:0], 2'b00};
      end
      hagc_pkg::MODE_DIV: begin
        rem_sh   = {rem[R_W-2:0], src[P_W-1]};
        trial    = {{(R_W-hagc_pkg::AMP_W){1'b0}}, dvs};
        src_next = {src[P_W-2:0], 1'b0};
      end
      default: begin
        rem_sh   = rem;
        trial    = '0;
        src_next = src;
      end
    endcase
    diff = {1'b0, rem_sh} - {1'b0, trial};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
      end else if (busy && count == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      src  <= operand;
      rem  <= '0;
      acc  <= '0;
      dvs  <= divisor;
      mode <= ctl.mode;
      count <= (ctl.mode == hagc_pkg::MODE_SQRT) ?
               hagc_pkg::CNT_W'(hagc_pkg::SQRT_STEPS - 1) :
               hagc_pkg::CNT_W'(hagc_pkg::DIV_STEPS - 1);
    end else if (busy) begin
      src <= src_next;
      if (!diff[R_W]) begin
        rem <= diff[R_W-1:0];
        acc <= {acc[hagc_pkg::GAIN_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        acc <= {acc[hagc_pkg::GAIN_W-2:0], 1'b0};
      end
      count <= count - 1'b1;
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign result   = acc;

endmodule

@@ rtl/hang_agc_gain_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hang_agc_gain_tracker: block-rate AGC with hang
// Channel  Direction  Payload
// s_*      in         tdata[39:0] block_power
// m_*      out        tdata[31:0] gain, tuser[0] hanging, tuser[1] peak_cut
// cfg_*    in         cfg_index selects headroom, hang_blocks, recovery_ratio
//
// Every item runs the square root (20 steps) and the peak-test multiply;
// recovery adds a ratio multiply, a cut adds the division (32 steps). The
// next transaction can follow in the cycle after the result is loaded.
// Reset is synchronous; no clearing pass. A result waiting in the output
// register does not stop the next transaction; a finished item holds in
// ST_OUT, with s_tready low, until that register is free.
// ----------------------------------------------------------------------------
module hang_agc_gain_tracker #(
  parameter int HANG_WIDTH = hagc_pkg::HANG_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [hagc_pkg::POWER_W-1:0]    s_tdata,   // [39:0] block_power
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [hagc_pkg::GAIN_W-1:0]     m_tdata,   // [31:0] gain
  output logic [1:0]                      m_tuser,   // [0] hanging, [1] peak_cut
  input  logic                            cfg_we,
  input  logic [hagc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hagc_pkg::CFG_W-1:0]      cfg_data
);

  localparam int PROD_W = hagc_pkg::GAIN_W + hagc_pkg::RATIO_W;

  hagc_pkg::state_t state, state_next;

  logic [hagc_pkg::HEAD_W-1:0]  headroom;
  logic [15:0]                  hang_blocks;
  logic [hagc_pkg::RATIO_W-1:0] recovery_ratio;
  logic [hagc_pkg::GAIN_W-1:0]  gain_value;
  logic [HANG_WIDTH-1:0]        hang_left;
  logic [hagc_pkg::AMP_W-1:0]   amp;
  logic                         hanging;
  logic                         cut;

  hagc_pkg::iter_ctl_t          iter_ctl;
  hagc_pkg::iter_sts_t          iter_sts;
  logic [hagc_pkg::POWER_W-1:0] iter_operand;
  logic [hagc_pkg::GAIN_W-1:0]  iter_result;

  logic [hagc_pkg::RATIO_W-1:0] mul_b;
  logic [PROD_W-1:0]            prod;

  logic [hagc_pkg::GAIN_W-1:0]  limit;
  logic                         over;
  logic [PROD_W-31:0]           grown;
  logic                         s_hs;

  assign s_hs     = s_tvalid && s_tready;
  assign s_tready = (state == hagc_pkg::ST_IDLE);
  assign limit    = {headroom, 16'h0000};
  assign over     = prod > {{(PROD_W-hagc_pkg::GAIN_W){1'b0}}, limit};
  assign grown    = prod[PROD_W-1:30];

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      hagc_pkg::ST_IDLE:   if (s_hs) state_next = hagc_pkg::ST_SQRT;
      hagc_pkg::ST_SQRT:   if (iter_sts.done) state_next = hagc_pkg::ST_LEVEL;
      hagc_pkg::ST_LEVEL:  state_next = hagc_pkg::ST_DECIDE;
      hagc_pkg::ST_DECIDE: begin
        priority if (over)          state_next = hagc_pkg::ST_DIV;
        else if (hang_left != '0)   state_next = hagc_pkg::ST_OUT;
        else                        state_next = hagc_pkg::ST_RECOV;
      end
      hagc_pkg::ST_DIV:    if (iter_sts.done) state_next = hagc_pkg::ST_OUT;
      hagc_pkg::ST_RECOV:  state_next = hagc_pkg::ST_OUT;
      hagc_pkg::ST_OUT:    if (!m_tvalid || m_tready) state_next = hagc_pkg::ST_IDLE;
      default:             state_next = hagc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: unit start, mode and operand, and multiplier operand
  always_comb begin
    iter_ctl.start = 1'b0;
    iter_ctl.mode  = hagc_pkg::MODE_SQRT;
    iter_operand   = s_tdata;
    mul_b          = {{(hagc_pkg::RATIO_W-hagc_pkg::AMP_W){1'b0}}, amp};
    unique case (state)
      hagc_pkg::ST_IDLE: iter_ctl.start = s_hs;
      hagc_pkg::ST_DECIDE: begin
        iter_ctl.start = over;
        iter_ctl.mode  = hagc_pkg::MODE_DIV;
        iter_operand   = {limit, 8'h00};
        mul_b          = recovery_ratio;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= hagc_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      headroom       <= hagc_pkg::HEADROOM_RESET;
      hang_blocks    <= hagc_pkg::HANG_BLOCKS_RESET;
      recovery_ratio <= hagc_pkg::RATIO_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hagc_pkg::REG_HEADROOM:    headroom       <= cfg_data[hagc_pkg::HEAD_W-1:0];
        hagc_pkg::REG_HANG_BLOCKS: hang_blocks    <= cfg_data[15:0];
        hagc_pkg::REG_RATIO:       recovery_ratio <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_value <= hagc_pkg::GAIN_RESET;
      hang_left  <= '0;
      hanging    <= 1'b0;
      cut        <= 1'b0;
    end else begin
      unique case (state)
        hagc_pkg::ST_DECIDE: begin
          hanging <= 1'b0;
          cut     <= 1'b0;
          priority if (over) begin
            cut       <= 1'b1;
            hang_left <= HANG_WIDTH'(hang_blocks);
          end else if (hang_left != '0) begin
            hanging   <= 1'b1;
            hang_left <= hang_left - 1'b1;
          end
        end
        hagc_pkg::ST_DIV: if (iter_sts.done) gain_value <= iter_result;
        // saturate the Q16.16 gain at the top of its range
        hagc_pkg::ST_RECOV: begin
          if (grown[PROD_W-31:hagc_pkg::GAIN_W] != '0) gain_value <= '1;
          else gain_value <= grown[hagc_pkg::GAIN_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == hagc_pkg::ST_SQRT && iter_sts.done) amp <= iter_result[hagc_pkg::AMP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == hagc_pkg::ST_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == hagc_pkg::ST_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= gain_value;
      m_tuser <= {cut, hanging};
    end
  end

  hagc_iter u_iter (
    .clk     (clk),
    .rst     (rst),
    .ctl     (iter_ctl),
    .operand (iter_operand),
    .divisor (amp),
    .sts     (iter_sts),
    .result  (iter_result)
  );

  hagc_mul u_mul (
    .clk  (clk),
    .a    (gain_value),
    .b    (mul_b),
    .prod (prod)
  );

`ifndef SYNTHESIS
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("hanging and peak_cut both set");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_hs |=> !s_tready)
    else $error("ready straight after a transaction");

  a_div_only_on_cut: assert property (@(posedge clk) disable iff (rst)
    (state == hagc_pkg::ST_DIV) |-> cut)
    else $error("division running without a cut");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    iter_sts.done |-> (state == hagc_pkg::ST_SQRT || state == hagc_pkg::ST_DIV))
    else $error("unit finished outside a wait state");

  a_start_idle_unit: assert property (@(posedge clk) disable iff (rst)
    iter_ctl.start |-> !iter_sts.busy)
    else $error("unit started while busy");
`endif

endmodule

@@ bench/tb_hang_agc_gain_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hang_agc_gain_tracker: self-checking bench for the hang AGC gain tracker
// Feeds block powers through the slave stream and tracks gain, hang counter
// and registers in a local model. Every output transaction is checked
// against the oldest predicted gain and flags. The run covers the square
// root and cut extremes, saturation, long hang, random peak/quiet sequences,
// then decay below unity and the zero-headroom and zero-gain ends.
// Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_hang_agc_gain_tracker;

  localparam int HANG_W = hagc_pkg::HANG_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam logic [hagc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [hagc_pkg::POWER_W-1:0] POWER_MAX = '1;
  localparam logic [hagc_pkg::POWER_W-1:0] POWER_TOP_SQUARE = 40'hFF_FFE0_0001;
  localparam logic [hagc_pkg::RATIO_W-1:0] RATIO_UNITY = 32'h4000_0000;
  localparam logic [hagc_pkg::RATIO_W-1:0] RATIO_NINE_TENTHS = 32'd966367641;
  localparam logic [hagc_pkg::RATIO_W-1:0] RATIO_TOP = '1;

  typedef struct packed {
    logic [hagc_pkg::GAIN_W-1:0] gain;
    logic                        hanging;
    logic                        peak_cut;
  } gain_res_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [hagc_pkg::POWER_W-1:0]   s_tdata = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [hagc_pkg::GAIN_W-1:0]    m_tdata;
  logic [1:0]                     m_tuser;
  logic                           cfg_we = 1'b0;
  logic [hagc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [hagc_pkg::CFG_W-1:0]     cfg_data = '0;

  // local copy of the tracker state and registers
  logic [hagc_pkg::GAIN_W-1:0]  gain_now = hagc_pkg::GAIN_RESET;
  logic [HANG_W-1:0]            hang_now = '0;
  logic [hagc_pkg::HEAD_W-1:0]  headroom_r = hagc_pkg::HEADROOM_RESET;
  logic [15:0]                  hang_blocks_r = hagc_pkg::HANG_BLOCKS_RESET;
  logic [hagc_pkg::RATIO_W-1:0] ratio_r = hagc_pkg::RATIO_RESET;

  logic [hagc_pkg::POWER_W-1:0] pending_power_q[$];
  gain_res_t                    expected_gain_q[$];

  bit          src_steady = 1'b0;
  bit          sink_steady = 1'b0;
  int unsigned src_gap = 0;
  int unsigned sink_stall = 0;
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;

  hang_agc_gain_tracker #(
    .HANG_WIDTH(HANG_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),    // [39:0] block_power
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),    // [31:0] gain
    .m_tuser  (m_tuser),    // [0] hanging, [1] peak_cut
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [hagc_pkg::AMP_W-1:0] block_amp(
      input logic [hagc_pkg::POWER_W-1:0] power);
    logic [hagc_pkg::AMP_W-1:0] root;
    logic [hagc_pkg::AMP_W-1:0] trial;
    root = '0;
    for (int b = hagc_pkg::AMP_W - 1; b >= 0; b--) begin
      trial = root | (hagc_pkg::AMP_W'(1) << b);
      if (64'(trial) * 64'(trial) <= 64'(power)) root = trial;
    end
    return root;
  endfunction

  // Update the local gain/hang state for one block and queue its result
  task automatic track_gain(input logic [hagc_pkg::POWER_W-1:0] power);
    logic [hagc_pkg::AMP_W-1:0] amp;
    logic [63:0]                level;
    logic [63:0]                limit;
    logic [63:0]                grown;
    gain_res_t                  res;
    amp = block_amp(power);
    level = 64'(gain_now) * 64'(amp);
    limit = 64'(headroom_r) << 16;
    res = '0;
    if (level > limit) begin
      gain_now = 32'(limit / 64'(amp));
      hang_now = HANG_W'(hang_blocks_r);
      res.peak_cut = 1'b1;
    end else if (hang_now != '0) begin
      hang_now = hang_now - 1'b1;
      res.hanging = 1'b1;
    end else begin
      grown = (64'(gain_now) * 64'(ratio_r)) >> 30;
      gain_now = (grown > 64'hFFFF_FFFF) ? '1 : grown[hagc_pkg::GAIN_W-1:0];
    end
    res.gain = gain_now;
    expected_gain_q.push_back(res);
  endtask

  function automatic int unsigned pick_gap(input bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 90);
  endfunction

  // log-uniform power: spans silence up to full scale
  function automatic logic [hagc_pkg::POWER_W-1:0] rand_power(input int unsigned lo_shift,
                                                               input int unsigned hi_shift);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[hagc_pkg::POWER_W-1:0] >> $urandom_range(lo_shift, hi_shift);
  endfunction

  task automatic write_reg(input logic [hagc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hagc_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      hagc_pkg::REG_HEADROOM:    headroom_r = val[hagc_pkg::HEAD_W-1:0];
      hagc_pkg::REG_HANG_BLOCKS: hang_blocks_r = val[15:0];
      hagc_pkg::REG_RATIO:       ratio_r = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every queued block has been accepted and answered
  task automatic drain();
    while (pending_power_q.size() != 0 || s_tvalid || expected_gain_q.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Peak/quiet sequences with the odd stray block
  task automatic queue_blocks(input int unsigned count);
    int unsigned n;
    int unsigned quiet;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 3) == 0) begin
        pending_power_q.push_back(rand_power(0, 40));
        n++;
      end else begin
        pending_power_q.push_back(rand_power(0, 12));
        quiet = $urandom_range(0, 10);
        for (int q = 0; q < quiet; q++) pending_power_q.push_back(rand_power(14, 40));
        n += quiet + 1;
      end
    end
  endtask

  // driver: present the next pending power, predict on each transaction
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      src_gap <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) track_gain(s_tdata);
      if (src_gap != 0) begin
        src_gap <= src_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_power_q.size() != 0) begin
        s_tdata <= pending_power_q.pop_front();
        s_tvalid <= 1'b1;
        src_gap <= pick_gap(src_steady);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  task automatic check_gain();
    gain_res_t want;
    if (expected_gain_q.size() == 0) begin
      $error("unexpected result: gain %0d hanging %0b peak_cut %0b",
             m_tdata, m_tuser[0], m_tuser[1]);
      fail_cnt++;
    end else begin
      want = expected_gain_q.pop_front();
      if (m_tdata !== want.gain) begin
        $error("gain: expected %0d, got %0d", want.gain, m_tdata);
        fail_cnt++;
      end
      if (m_tuser[0] !== want.hanging) begin
        $error("hanging: expected %0b, got %0b", want.hanging, m_tuser[0]);
        fail_cnt++;
      end
      if (m_tuser[1] !== want.peak_cut) begin
        $error("peak_cut: expected %0b, got %0b", want.peak_cut, m_tuser[1]);
        fail_cnt++;
      end
    end
  endtask

  // monitor: random back-pressure, check each result transaction
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_stall <= 0;
    end else begin
      if (m_tvalid && m_tready) check_gain();
      if (sink_stall != 0) begin
        sink_stall <= sink_stall - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        sink_stall <= pick_gap(sink_steady);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_hang_agc_gain_tracker failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [hagc_pkg::CFG_W-1:0]  v;
    logic [hagc_pkg::HEAD_W-1:0] head_pick;
    int unsigned r;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: recovery from the reset gain
    pending_power_q.push_back('0);
    pending_power_q.push_back(40'd1);
    drain();

    // fastest growth to saturation, then a full-scale cut with no hang
    write_reg(hagc_pkg::REG_HANG_BLOCKS, 32'd0);
    write_reg(hagc_pkg::REG_HEADROOM, 32'd65535);
    write_reg(hagc_pkg::REG_RATIO, RATIO_TOP);
    write_reg(REG_UNUSED, $urandom);
    for (int i = 0; i < 4; i++) pending_power_q.push_back('0);
    pending_power_q.push_back(POWER_MAX);
    pending_power_q.push_back(40'd1);
    pending_power_q.push_back(40'd2);
    pending_power_q.push_back(40'd3);
    pending_power_q.push_back(40'd4);
    pending_power_q.push_back(POWER_TOP_SQUARE);
    pending_power_q.push_back(POWER_TOP_SQUARE - 1'b1);
    pending_power_q.push_back(40'h80_0000_0000);
    drain();

    // longest hang load; upper data bits must be dropped
    write_reg(hagc_pkg::REG_HANG_BLOCKS, 32'hA5A5_FFFF);
    write_reg(hagc_pkg::REG_HEADROOM, {16'hFFFF, hagc_pkg::HEADROOM_RESET});
    pending_power_q.push_back(POWER_MAX);
    pending_power_q.push_back(POWER_TOP_SQUARE - 1'b1);
    pending_power_q.push_back(40'd5);
    drain();

    // lower headroom forces a fresh cut with a short hang
    write_reg(hagc_pkg::REG_HEADROOM, 32'd1000);
    write_reg(hagc_pkg::REG_HANG_BLOCKS, 32'd3);
    pending_power_q.push_back(POWER_MAX);
    for (int i = 0; i < 4; i++) pending_power_q.push_back('0);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      src_steady = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      head_pick = hagc_pkg::HEAD_W'($urandom_range(16, 65535));
      v = $urandom;
      write_reg(hagc_pkg::REG_HEADROOM, {v[31:16], head_pick});
      r = $urandom_range(0, 9);
      v = $urandom;
      if (r == 0) v[15:0] = '0;
      else if (r == 1) v[15:0] = 16'($urandom_range(9, 200));
      else v[15:0] = 16'($urandom_range(1, 8));
      write_reg(hagc_pkg::REG_HANG_BLOCKS, v);
      if ($urandom_range(0, 9) == 0) write_reg(hagc_pkg::REG_RATIO, RATIO_UNITY);
      else write_reg(hagc_pkg::REG_RATIO, $urandom_range(RATIO_UNITY, RATIO_TOP));
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, $urandom);
      queue_blocks(100);
      drain();
    end

    // ratio below one: gain decays between peaks
    src_steady = 1'b0;
    sink_steady = 1'b0;
    write_reg(hagc_pkg::REG_HEADROOM, 32'd60000);
    write_reg(hagc_pkg::REG_HANG_BLOCKS, 32'($urandom_range(0, 2)));
    write_reg(hagc_pkg::REG_RATIO, $urandom_range(RATIO_NINE_TENTHS, RATIO_UNITY - 1));
    queue_blocks(40);
    drain();

    // zero headroom cuts to zero gain, zero ratio keeps it there
    write_reg(hagc_pkg::REG_HANG_BLOCKS, 32'd0);
    write_reg(hagc_pkg::REG_HEADROOM, 32'd0);
    write_reg(hagc_pkg::REG_RATIO, 32'd0);
    pending_power_q.push_back(POWER_MAX);
    pending_power_q.push_back('0);
    queue_blocks(20);
    drain();

    // zero gain stays zero whatever the registers say
    write_reg(hagc_pkg::REG_HANG_BLOCKS, 32'd65535);
    write_reg(hagc_pkg::REG_HEADROOM, 32'd65535);
    write_reg(hagc_pkg::REG_RATIO, RATIO_TOP);
    queue_blocks(20);
    drain();

    repeat (64) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("tb_hang_agc_gain_tracker passed");
    end else begin
      $display("tb_hang_agc_gain_tracker failed");
    end
    $finish;
  end

endmodule

@@ hang_agc_gain_tracker.f @@
rtl/hagc_pkg.sv
rtl/hagc_mul.sv
rtl/hagc_iter.sv
rtl/hang_agc_gain_tracker.sv
bench/tb_hang_agc_gain_tracker.sv
